// ===== rtl/core/wsfd_pkg.sv =====
// Shared types and constants for the frame deframer.
package wsfd_pkg;

  // Status codes carried with each result
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RSV_BITS = 2'd1;
  localparam logic [1:0] STATUS_BAD_OPC  = 2'd2;

  // Supported opcodes
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;

  // Header field masks and length escape codes
  localparam logic [7:0] HDR_RSV_MASK = 8'h70;
  localparam logic [6:0] LEN7_EXT16   = 7'h7E;
  localparam logic [6:0] LEN7_EXT64   = 7'h7F;

  // Byte counts of the extended length and the masking key
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       data_valid;
    logic [3:0] frame_opcode;
    logic       frame_final;
    logic       frame_end;
    logic [1:0] status;
  } wsfd_result_t;

endpackage

// ===== rtl/core/wsfd_parser.sv =====
// Header, length, key and payload parser; one byte per cycle with byte_take high.
module wsfd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_take,
  input  logic [7:0]            stream_byte,
  output logic                  res_valid,
  output wsfd_pkg::wsfd_result_t res
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t                   parse_phase, parse_phase_next;
  logic [3:0]               field_byte_count, field_byte_count_next;
  logic [LENGTH_BITS-1:0]   payload_remaining, payload_remaining_next;
  logic [31:0]              mask_key, mask_key_next;
  logic [1:0]               key_index, key_index_next;
  logic [3:0]               cur_opcode, cur_opcode_next;
  logic                     cur_final, cur_final_next;
  logic                     cur_masked, cur_masked_next;

  logic [3:0]               count_inc;
  logic [3:0]               ext_need;
  logic [LENGTH_BITS-1:0]   rem_shift;
  logic [LENGTH_BITS-1:0]   len_value;
  logic                     len_done;
  logic [7:0]               key_byte;

  assign count_inc = field_byte_count + 4'd1;
  assign ext_need  = (parse_phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
  assign rem_shift = {payload_remaining[LENGTH_BITS-9:0], stream_byte};

  // Pick the key byte for the current payload byte, first key byte on top
  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Work out the next parser state and any result for the accepted byte
  always_comb begin
    parse_phase_next       = parse_phase;
    field_byte_count_next  = field_byte_count;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    cur_opcode_next        = cur_opcode;
    cur_final_next         = cur_final;
    cur_masked_next        = cur_masked;
    res_valid              = 1'b0;
    res                    = '0;
    res.frame_opcode       = cur_opcode;
    res.frame_final        = cur_final;
    len_done               = 1'b0;
    len_value              = payload_remaining;

    unique case (parse_phase)
      PH_HDR1: begin
        cur_masked_next       = stream_byte[7];
        field_byte_count_next = '0;
        if (stream_byte[6:0] == LEN7_EXT16) begin
          payload_remaining_next = '0;
          parse_phase_next       = PH_EXT16;
        end else if (stream_byte[6:0] == LEN7_EXT64) begin
          payload_remaining_next = '0;
          parse_phase_next       = PH_EXT64;
        end else begin
          len_value = LENGTH_BITS'(stream_byte[6:0]);
          len_done  = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        payload_remaining_next = rem_shift;
        field_byte_count_next  = count_inc;
        len_value              = rem_shift;
        len_done               = (count_inc >= ext_need);
      end
      PH_KEY: begin
        mask_key_next         = {mask_key[23:0], stream_byte};
        field_byte_count_next = count_inc;
        if (count_inc >= KEY_BYTES) begin
          key_index_next = '0;
          if (payload_remaining == '0) begin
            parse_phase_next = PH_HDR0;
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        key_index_next         = key_index + 2'd1;
        payload_remaining_next = payload_remaining - LENGTH_BITS'(1);
        res_valid              = 1'b1;
        res.data_valid         = 1'b1;
        res.payload_byte       = cur_masked ? (stream_byte ^ key_byte) : stream_byte;
        if (payload_remaining == LENGTH_BITS'(1)) begin
          res.frame_end    = 1'b1;
          parse_phase_next = PH_HDR0;
        end
      end
      default: begin
        cur_opcode_next  = stream_byte[3:0];
        cur_final_next   = stream_byte[7];
        res.frame_opcode = stream_byte[3:0];
        res.frame_final  = stream_byte[7];
        if ((stream_byte & HDR_RSV_MASK) != '0) begin
          parse_phase_next = PH_HDR0;
          res_valid        = 1'b1;
          res.status       = STATUS_RSV_BITS;
        end else if (stream_byte[3:0] != OPC_TEXT && stream_byte[3:0] != OPC_CLOSE) begin
          parse_phase_next = PH_HDR0;
          res_valid        = 1'b1;
          res.status       = STATUS_BAD_OPC;
        end else begin
          parse_phase_next = PH_HDR1;
        end
      end
    endcase

    // Length complete: go to the key, or straight to the payload
    if (len_done) begin
      payload_remaining_next = len_value;
      if (cur_masked_next) begin
        parse_phase_next      = PH_KEY;
        field_byte_count_next = '0;
        mask_key_next         = '0;
      end else begin
        key_index_next = '0;
        if (len_value == '0) begin
          parse_phase_next = PH_HDR0;
          res_valid        = 1'b1;
          res.frame_end    = 1'b1;
        end else begin
          parse_phase_next = PH_DATA;
        end
      end
    end

    if (!byte_take) begin
      res_valid = 1'b0;
    end
  end

  // Hold parser state; advance only on an accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HDR0;
      field_byte_count  <= '0;
      payload_remaining <= '0;
      mask_key          <= '0;
      key_index         <= '0;
      cur_opcode        <= '0;
      cur_final         <= 1'b0;
      cur_masked        <= 1'b0;
    end else if (byte_take) begin
      parse_phase       <= parse_phase_next;
      field_byte_count  <= field_byte_count_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      key_index         <= key_index_next;
      cur_opcode        <= cur_opcode_next;
      cur_final         <= cur_final_next;
      cur_masked        <= cur_masked_next;
    end
  end

endmodule

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// A result reaches the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while results drain; only payload bytes, a rejected first
// header byte and the last length or key byte of an empty frame give a result.
// Each byte is parsed in one pass through a LENGTH_BITS-wide decrement and compare.
// Reset (rst, synchronous, active high) returns the parser to waiting for a
// first header byte and empties the output register.
module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                      // [12] frame_final, [14:13] status, [15] zero
  output logic        m_axis_tuser,   // [0] data_valid
  output logic        m_axis_tlast    // frame_end
);
  import wsfd_pkg::*;

  logic         byte_take;
  logic         res_valid;
  wsfd_result_t res;
  wsfd_result_t out_res;
  logic         out_valid;

  // Take a byte whenever the output register is free or being drained
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign byte_take     = s_axis_tvalid && s_axis_tready;

  wsfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_take   (byte_take),
    .stream_byte (s_axis_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register: load a new result, drop a taken one, otherwise hold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.status, out_res.frame_final,
                          out_res.frame_opcode, out_res.payload_byte};
  assign m_axis_tuser  = out_res.data_valid;
  assign m_axis_tlast  = out_res.frame_end;

endmodule

// ===== rtl/core/wsfd_checker.sv =====
// Port-level checks for the frame deframer, bound to the top level.
module wsfd_assertions (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import wsfd_pkg::*;

  // A stalled result holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A result without payload carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("non-data result with a payload byte");

  // An error result never carries data nor ends a frame
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[14:13] != STATUS_OK |->
      !m_axis_tuser && !m_axis_tlast)
    else $error("error result with data or frame end");

  // Data and frame ends always carry a good status; bit 15 of tdata is zero
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser || m_axis_tlast) |->
      m_axis_tdata[14:13] == STATUS_OK && !m_axis_tdata[15])
    else $error("data or frame end with bad status");

  // Input ready while the output is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

bind websocket_frame_deframer_top wsfd_assertions u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/wsfd_checker.sv =====
// Checker for the frame deframer: predicts each result and compares the output stream.
`timescale 1ns / 100ps

module wsfd_checker #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                      // [12] frame_final, [14:13] status, [15] zero
  input  logic        m_axis_tuser,   // [0] data_valid
  input  logic        m_axis_tlast,   // frame_end
  output int          error_count,
  output int          results_pending
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } parse_state_t;

  // Shadow copy of the parser state
  parse_state_t           parse_state;
  logic [3:0]             len_cnt;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [31:0]            key_word;
  logic [1:0]             key_pos;
  logic [3:0]             hdr_opcode;
  logic                   hdr_final;
  logic                   hdr_masked;

  wsfd_result_t expected_q[$];
  int           mismatches;

  // Start the payload, or close an empty frame at once
  task automatic open_payload(output bit has, output wsfd_result_t r);
    has = 1'b0;
    r = '0;
    key_pos = 2'd0;
    if (bytes_left == '0) begin
      parse_state = PH_HDR0;
      r.frame_opcode = hdr_opcode;
      r.frame_final  = hdr_final;
      r.frame_end    = 1'b1;
      r.status       = STATUS_OK;
      has = 1'b1;
    end else begin
      parse_state = PH_DATA;
    end
  endtask

  // Length is known: collect the key first if the frame is masked
  task automatic length_complete(output bit has, output wsfd_result_t r);
    has = 1'b0;
    r = '0;
    if (hdr_masked) begin
      parse_state = PH_KEY;
      len_cnt = 4'd0;
      key_word = '0;
    end else begin
      open_payload(has, r);
    end
  endtask

  // Advance the shadow parser by one stream byte
  task automatic parse_byte(input logic [7:0] b, output bit has, output wsfd_result_t r);
    logic [7:0] k;
    has = 1'b0;
    r = '0;
    k = '0;
    case (parse_state)
      PH_HDR1: begin
        hdr_masked = b[7];
        len_cnt = 4'd0;
        bytes_left = '0;
        if (b[6:0] == LEN7_EXT16) begin
          parse_state = PH_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          parse_state = PH_EXT64;
        end else begin
          bytes_left = LENGTH_BITS'(b[6:0]);
          length_complete(has, r);
        end
      end
      PH_EXT16, PH_EXT64: begin
        bytes_left = (bytes_left << 8) | LENGTH_BITS'(b);
        len_cnt = len_cnt + 4'd1;
        if (len_cnt >= ((parse_state == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES))
          length_complete(has, r);
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        len_cnt = len_cnt + 4'd1;
        if (len_cnt >= KEY_BYTES)
          open_payload(has, r);
      end
      PH_DATA: begin
        if (hdr_masked)
          k = key_word[8*(3-key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 1'b1;
        r.payload_byte = b ^ k;
        r.data_valid   = 1'b1;
        r.frame_opcode = hdr_opcode;
        r.frame_final  = hdr_final;
        r.status       = STATUS_OK;
        if (bytes_left == '0) begin
          r.frame_end = 1'b1;
          parse_state = PH_HDR0;
        end
        has = 1'b1;
      end
      default: begin
        hdr_opcode = b[3:0];
        hdr_final = b[7];
        r.frame_opcode = b[3:0];
        r.frame_final  = b[7];
        if ((b & HDR_RSV_MASK) != 8'h00) begin
          // Reserved bits win over a bad opcode
          r.status = STATUS_RSV_BITS;
          parse_state = PH_HDR0;
          has = 1'b1;
        end else if (b[3:0] != OPC_TEXT && b[3:0] != OPC_CLOSE) begin
          r.status = STATUS_BAD_OPC;
          parse_state = PH_HDR0;
          has = 1'b1;
        end else begin
          parse_state = PH_HDR1;
        end
      end
    endcase
  endtask

  function automatic int field_differs(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare output transfers first, then predict from input transfers
  always @(posedge clk) begin
    wsfd_result_t got;
    wsfd_result_t want;
    wsfd_result_t pred;
    bit           has;
    int           bad;
    if (rst) begin
      parse_state = PH_HDR0;
      len_cnt     = '0;
      bytes_left  = '0;
      key_word    = '0;
      key_pos     = '0;
      hdr_opcode  = '0;
      hdr_final   = 1'b0;
      hdr_masked  = 1'b0;
      expected_q.delete();
      mismatches = 0;
      error_count <= 0;
      results_pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_byte = m_axis_tdata[7:0];
        got.frame_opcode = m_axis_tdata[11:8];
        got.frame_final  = m_axis_tdata[12];
        got.status       = m_axis_tdata[14:13];
        got.data_valid   = m_axis_tuser;
        got.frame_end    = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: tdata 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          bad = 0;
          bad += field_differs("payload_byte", 32'(want.payload_byte),
                               32'(got.payload_byte));
          bad += field_differs("data_valid", 32'(want.data_valid), 32'(got.data_valid));
          bad += field_differs("frame_opcode", 32'(want.frame_opcode),
                               32'(got.frame_opcode));
          bad += field_differs("frame_final", 32'(want.frame_final), 32'(got.frame_final));
          bad += field_differs("frame_end", 32'(want.frame_end), 32'(got.frame_end));
          bad += field_differs("status", 32'(want.status), 32'(got.status));
          if (bad != 0)
            mismatches++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, has, pred);
        if (has)
          expected_q.push_back(pred);
      end
      error_count <= mismatches;
      results_pending <= expected_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
  import wsfd_pkg::*;

  localparam int LENGTH_BITS = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int error_count;
  int results_pending;

  logic [7:0] wire_bytes[$];

  // Receiver stall pattern state
  int unsigned sink_mode = 0;
  int unsigned sink_left = 0;
  int unsigned sink_tick = 0;

  websocket_frame_deframer_top #(
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wsfd_checker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver: pick a new stall pattern at random each time the current one runs out
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(20, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_tick <= sink_tick + 1;
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 5) == 0);
      default: m_axis_tready <= (sink_tick[1:0] != 2'b00);
    endcase
  end

  // Queue one frame; only the first payload_sent payload bytes are emitted
  task automatic push_frame(input bit fin, input logic [3:0] opc, input bit masked,
                            input int unsigned len, input int enc,
                            input int unsigned payload_sent);
    logic [63:0] len64;
    len64 = 64'(len);
    wire_bytes.push_back({fin, 3'b000, opc});
    case (enc)
      0: wire_bytes.push_back({masked, len64[6:0]});
      1: begin
        wire_bytes.push_back({masked, LEN7_EXT16});
        wire_bytes.push_back(len64[15:8]);
        wire_bytes.push_back(len64[7:0]);
      end
      default: begin
        wire_bytes.push_back({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--)
          wire_bytes.push_back(len64[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 0; i < 4; i++)
        wire_bytes.push_back(8'($urandom));
    for (int unsigned i = 0; i < payload_sent; i++)
      wire_bytes.push_back(8'($urandom));
  endtask

  // Fill the queue with mostly well-formed frames, some broken ones and noise
  task automatic build_random(input int unsigned target);
    int unsigned pick;
    int unsigned len;
    int          enc;
    logic [7:0]  b;
    logic [3:0]  opc;
    while (wire_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        case ($urandom_range(0, 99)) inside
          [0:44]:  begin len = $urandom_range(0, 9);     enc = 0; end
          [45:64]: begin len = $urandom_range(10, 125);  enc = 0; end
          [65:81]: begin len = $urandom_range(0, 200);   enc = 1; end
          [82:83]: begin len = $urandom_range(300, 600); enc = 1; end
          default: begin len = $urandom_range(0, 60);    enc = 2; end
        endcase
        opc = $urandom_range(0, 1) ? OPC_TEXT : OPC_CLOSE;
        if (pick < 78 || len == 0)
          push_frame(1'($urandom_range(0, 1)), opc, 1'($urandom_range(0, 1)), len, enc,
                     len);
        else
          // Truncated frame: the next frame's bytes land in its payload
          push_frame(1'($urandom_range(0, 1)), opc, 1'($urandom_range(0, 1)), len, enc,
                     $urandom_range(0, len - 1));
      end else if (pick < 93) begin
        if ($urandom_range(0, 1)) begin
          b = 8'($urandom);
          b[4 +: 3] = 3'($urandom_range(1, 7));
        end else begin
          do opc = 4'($urandom); while (opc == OPC_TEXT || opc == OPC_CLOSE);
          b = {1'($urandom), 3'b000, opc};
        end
        wire_bytes.push_back(b);
      end else begin
        // Noise byte; a valid header gets a short length byte after it
        b = 8'($urandom);
        wire_bytes.push_back(b);
        if ((b & HDR_RSV_MASK) == 8'h00 && (b[3:0] == OPC_TEXT || b[3:0] == OPC_CLOSE))
          wire_bytes.push_back(8'($urandom) & 8'h9F);
      end
    end
  endtask

  // Offer one byte and hold it until the transfer completes
  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain the queue in bursts with random gaps
  task automatic send_queue();
    int unsigned burst;
    int unsigned gap;
    while (wire_bytes.size() != 0) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int unsigned i = 0; i < burst && wire_bytes.size() != 0; i++)
        send_byte(wire_bytes.pop_front());
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drained();
    @(posedge clk);
    while (results_pending != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reserved bits, reserved plus bad opcode, opcode zero,
    // empty frames plain and masked, masked text with extreme key and data,
    // 16-bit extended length
    wire_bytes = {8'hF1, 8'h72, 8'h80,
                  8'h81, 8'h00,
                  8'h88, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A,
                  8'h01, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00,
                  8'h81, {1'b0, LEN7_EXT16}, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h3C};
    send_queue();
    wait_drained();

    // Random, in two halves with a full drain between them
    for (int half = 0; half < 2; half++) begin
      build_random(650);
      send_queue();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && results_pending == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
